// ===== rtl/core/pipeline_hazard_timing_model_assert.svh =====
// assertion macros for the pipeline hazard timing model checker
`ifndef PIPELINE_HAZARD_TIMING_MODEL_ASSERT_SVH
`define PIPELINE_HAZARD_TIMING_MODEL_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pht_pkg.sv =====
// shared types and constants for the pipeline hazard timing model
`default_nettype none

package pht_pkg;

    localparam int COUNTER_WIDTH_DEFAULT = 32;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 8;
    localparam logic [7:0] MISS_DELAY_RESET = 8'd10;
    localparam logic [31:0] SEQ_STEP = 32'd4;

    // config register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PREDICT_TAKEN = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MISS_DELAY = 2'd1;

    // instruction kinds
    localparam logic [2:0] KIND_ALU = 3'd1;
    localparam logic [2:0] KIND_LOAD = 3'd2;
    localparam logic [2:0] KIND_STORE = 3'd3;
    localparam logic [2:0] KIND_BRANCH = 3'd4;

    typedef struct packed {
        logic [31:0] addr;
        logic [2:0]  kind;
        logic [4:0]  ra;
        logic [15:0] rb;
        logic [4:0]  rd;
        logic        hit;
    } stage_entry_t;

    // per-item events from hazard unit to counters
    typedef struct packed {
        logic       retire_inc;
        logic       branch_inc;
        logic       correct_inc;
        logic       mispredicted;
        logic       load_use_stall;
        logic       data_miss;
        logic [8:0] cycles_added;
    } event_t;

    typedef struct packed {
        logic        retired;
        logic [31:0] retired_address;
        logic [8:0]  cycles_added;
        logic        mispredicted;
        logic        load_use_stall;
        logic        data_miss;
        logic [31:0] cycle_total;
        logic [31:0] retired_total;
        logic [31:0] branch_total;
        logic [31:0] correct_total;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/pht_stages.sv =====
// decode, alu, memory and writeback stage entry registers
`default_nettype none

module pht_stages (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire pht_pkg::stage_entry_t fetch,
    output pht_pkg::stage_entry_t      dec,
    output pht_pkg::stage_entry_t      alu,
    output pht_pkg::stage_entry_t      mem,
    output pht_pkg::stage_entry_t      wb
);

    pht_pkg::stage_entry_t dec_reg, alu_reg, mem_reg, wb_reg;
    pht_pkg::stage_entry_t fetch_clean;

    // a zero address is a bubble, all fields cleared
    assign fetch_clean = (fetch.addr == 32'd0) ? '0 : fetch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg <= '0;
            alu_reg <= '0;
            mem_reg <= '0;
            wb_reg  <= '0;
        end
        else if (advance)
        begin
            wb_reg  <= mem_reg;
            mem_reg <= alu_reg;
            alu_reg <= dec_reg;
            dec_reg <= fetch_clean;
        end
    end

    assign dec = dec_reg;
    assign alu = alu_reg;
    assign mem = mem_reg;
    assign wb  = wb_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pht_hazard_unit.sv =====
// branch, load-use and data miss checks plus per-item cycle charge
`default_nettype none

module pht_hazard_unit (
    input  wire logic                  predict_taken,
    input  wire logic [7:0]            miss_delay,
    input  wire logic [31:0]           fetch_addr,
    input  wire pht_pkg::stage_entry_t dec,
    input  wire pht_pkg::stage_entry_t alu,
    input  wire pht_pkg::stage_entry_t mem,
    input  wire pht_pkg::stage_entry_t wb,
    output pht_pkg::event_t            ev
);

    logic       dec_branch;
    logic       taken;
    logic       judged;
    logic       lu_hit;
    logic       mem_access;
    logic [7:0] miss_extra;

    always_comb
    begin
        dec_branch = (dec.kind == pht_pkg::KIND_BRANCH);
        taken      = (fetch_addr != (dec.addr + pht_pkg::SEQ_STEP));
        judged     = dec_branch && (fetch_addr != 32'd0);

        // load in memory feeding the alu-stage instruction
        lu_hit = 1'b0;
        if (mem.kind == pht_pkg::KIND_LOAD)
        begin
            if (alu.kind == pht_pkg::KIND_ALU)
                lu_hit = (alu.ra == mem.rd) || (alu.rb == {11'd0, mem.rd});
            else if (alu.kind == pht_pkg::KIND_LOAD || alu.kind == pht_pkg::KIND_STORE)
                lu_hit = (alu.ra == mem.rd);
        end

        mem_access = (mem.kind == pht_pkg::KIND_LOAD) || (mem.kind == pht_pkg::KIND_STORE);
        // zero delay saturates to no extra cycles
        miss_extra = (miss_delay == 8'd0) ? 8'd0 : (miss_delay - 8'd1);

        ev.retire_inc     = (wb.addr != 32'd0);
        ev.branch_inc     = dec_branch;
        ev.correct_inc    = judged && (taken == predict_taken);
        ev.mispredicted   = judged && (taken != predict_taken);
        ev.load_use_stall = lu_hit;
        ev.data_miss      = mem_access && !mem.hit;
        ev.cycles_added   = 9'd1 + {8'd0, ev.mispredicted} + {8'd0, lu_hit}
                          + (ev.data_miss ? {1'b0, miss_extra} : 9'd0);
    end

endmodule

`default_nettype wire

// ===== rtl/core/pht_counters.sv =====
// running cycle, retire, branch and correct-prediction counters
`default_nettype none

module pht_counters #(
    parameter int COUNTER_WIDTH = pht_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire pht_pkg::event_t ev,
    output logic [31:0]          cycle_total,
    output logic [31:0]          retired_total,
    output logic [31:0]          branch_total,
    output logic [31:0]          correct_total
);

    logic [COUNTER_WIDTH-1:0] cycle_reg, retire_reg, branch_reg, correct_reg;
    logic [COUNTER_WIDTH-1:0] cycle_next, retire_next, branch_next, correct_next;

    always_comb
    begin
        cycle_next   = cycle_reg + {{(COUNTER_WIDTH-9){1'b0}}, ev.cycles_added};
        retire_next  = retire_reg + {{(COUNTER_WIDTH-1){1'b0}}, ev.retire_inc};
        branch_next  = branch_reg + {{(COUNTER_WIDTH-1){1'b0}}, ev.branch_inc};
        correct_next = correct_reg + {{(COUNTER_WIDTH-1){1'b0}}, ev.correct_inc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_reg   <= '0;
            retire_reg  <= '0;
            branch_reg  <= '0;
            correct_reg <= '0;
        end
        else if (advance)
        begin
            cycle_reg   <= cycle_next;
            retire_reg  <= retire_next;
            branch_reg  <= branch_next;
            correct_reg <= correct_next;
        end
    end

    // totals reported are the post-update values, low 32 bits
    assign cycle_total   = 32'(cycle_next);
    assign retired_total = 32'(retire_next);
    assign branch_total  = 32'(branch_next);
    assign correct_total = 32'(correct_next);

endmodule

`default_nettype wire

// ===== rtl/core/pht_result_buffer.sv =====
// output register with one skid entry
`default_nettype none

module pht_result_buffer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire pht_pkg::result_t in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output pht_pkg::result_t      out_data
);

    logic             out_valid_reg, skid_valid_reg;
    pht_pkg::result_t out_data_reg, skid_data_reg;
    logic             out_take, in_take;

    assign out_take = out_valid_reg && !out_stall;
    assign in_take  = in_valid && !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            if (out_valid_reg && !out_take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_data_reg <= skid_data_reg;
        end
        else if (in_take)
        begin
            if (out_valid_reg && !out_take)
                skid_data_reg <= in_data;
            else
                out_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pipeline_hazard_timing_model.sv =====
// top level of the five-stage pipeline hazard timing model
// each result is registered, in the skid entry while the output is held
// throughput: one fetch transfer per cycle, held off only when both the output
//   register and its skid entry are full
// reset: stage entries are bubbles, counters zero, predict_taken 0, miss_delay 10
`default_nettype none

module pipeline_hazard_timing_model #(
    parameter int COUNTER_WIDTH = pht_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration writes
    input  wire logic                                  cfg_we,
    input  wire logic [pht_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [pht_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    // fetch channel
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [31:0]                           fetch_address,
    input  wire logic [2:0]                            instr_kind,
    input  wire logic [4:0]                            source_a,
    input  wire logic [15:0]                           source_b,
    input  wire logic [4:0]                            dest_register,
    input  wire logic                                  data_hit,
    // result channel
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       retired,
    output logic [31:0]                                retired_address,
    output logic [8:0]                                 cycles_added,
    output logic                                       mispredicted,
    output logic                                       load_use_stall,
    output logic                                       data_miss,
    output logic [31:0]                                cycle_total,
    output logic [31:0]                                retired_total,
    output logic [31:0]                                branch_total,
    output logic [31:0]                                correct_total
);

    // configuration registers
    logic       predict_taken_reg;
    logic [7:0] miss_delay_reg;

    // fetch transfer advances the stages and counters together
    logic                  accept;
    pht_pkg::stage_entry_t fetch_entry;
    pht_pkg::stage_entry_t dec, alu, mem, wb;
    pht_pkg::event_t       ev;
    pht_pkg::result_t      res, res_out;
    logic [31:0]           cyc_tot, ret_tot, br_tot, cor_tot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            predict_taken_reg <= 1'b0;
            miss_delay_reg    <= pht_pkg::MISS_DELAY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pht_pkg::CFG_PREDICT_TAKEN: predict_taken_reg <= cfg_data[0];
                pht_pkg::CFG_MISS_DELAY:    miss_delay_reg    <= cfg_data;
                default:                    ; // unmapped index, write dropped
            endcase
        end
    end

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        fetch_entry.addr = fetch_address;
        fetch_entry.kind = instr_kind;
        fetch_entry.ra   = source_a;
        fetch_entry.rb   = source_b;
        fetch_entry.rd   = dest_register;
        fetch_entry.hit  = data_hit;
    end

    pht_stages u_stages (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .fetch   (fetch_entry),
        .dec     (dec),
        .alu     (alu),
        .mem     (mem),
        .wb      (wb)
    );

    // hazard checks look at the stages before the shift and the raw fetch address;
    // a bubble fetch has address zero either way
    pht_hazard_unit u_hazard (
        .predict_taken (predict_taken_reg),
        .miss_delay    (miss_delay_reg),
        .fetch_addr    (fetch_address),
        .dec           (dec),
        .alu           (alu),
        .mem           (mem),
        .wb            (wb),
        .ev            (ev)
    );

    pht_counters #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_counters (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (accept),
        .ev            (ev),
        .cycle_total   (cyc_tot),
        .retired_total (ret_tot),
        .branch_total  (br_tot),
        .correct_total (cor_tot)
    );

    always_comb
    begin
        res.retired         = ev.retire_inc;
        res.retired_address = wb.addr;
        res.cycles_added    = ev.cycles_added;
        res.mispredicted    = ev.mispredicted;
        res.load_use_stall  = ev.load_use_stall;
        res.data_miss       = ev.data_miss;
        res.cycle_total     = cyc_tot;
        res.retired_total   = ret_tot;
        res.branch_total    = br_tot;
        res.correct_total   = cor_tot;
    end

    // result register plus skid so a stalled consumer does not stop fetch at once
    pht_result_buffer u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (res_out)
    );

    assign retired         = res_out.retired;
    assign retired_address = res_out.retired_address;
    assign cycles_added    = res_out.cycles_added;
    assign mispredicted    = res_out.mispredicted;
    assign load_use_stall  = res_out.load_use_stall;
    assign data_miss       = res_out.data_miss;
    assign cycle_total     = res_out.cycle_total;
    assign retired_total   = res_out.retired_total;
    assign branch_total    = res_out.branch_total;
    assign correct_total   = res_out.correct_total;

endmodule

`default_nettype wire

// ===== rtl/core/pht_checker.sv =====
// port-level checker for the pipeline hazard timing model, with its bind
`default_nettype none

`include "pipeline_hazard_timing_model_assert.svh"

module pht_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        retired,
    input wire logic [31:0] retired_address,
    input wire logic [8:0]  cycles_added,
    input wire logic        mispredicted,
    input wire logic        load_use_stall
);

    `PHT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
    `PHT_ASSERT_NEXT(a_in_to_out, in_valid && !in_stall, out_valid, "fetch transfer gave no result")
    `PHT_ASSERT_NOW(a_base_cycle, out_valid, cycles_added != 9'd0, "step charged no cycles")
    `PHT_ASSERT_NOW(a_bubble_addr, out_valid && !retired, retired_address == 32'd0, "bubble retired with address")
    `PHT_ASSERT_NOW(a_stall_cost, out_valid && (mispredicted || load_use_stall), cycles_added >= 9'd2, "stall not charged")

endmodule

bind pipeline_hazard_timing_model pht_checker u_pht_checker (.*);

`default_nettype wire

// ===== test/tb_pipeline_hazard_timing_model.sv =====
// self-checking testbench for the pipeline hazard timing model
`timescale 1ns / 100ps

module tb_pipeline_hazard_timing_model;

    // kinds the package leaves unnamed: plain instructions and the undefined codes
    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_UNDEFINED = 3'd7;

    // register indexes that decode to nothing
    localparam logic [pht_pkg::CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [pht_pkg::CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = 2'd3;

    // cycles without any transfer before the run is declared hung
    localparam int HANG_LIMIT = 3000;
    localparam int MAX_REPORTS = 10;

    typedef enum int {STG_DECODE, STG_ALU, STG_MEM, STG_WB} stage_t;
    typedef enum logic {ROW_FETCH, ROW_WRITE} row_kind_t;

    // one line of the directed table: a fetch, or a register write
    typedef struct {
        row_kind_t             op;
        pht_pkg::stage_entry_t fetch;
        bit                    has_result;
        pht_pkg::result_t      result;
        logic [1:0]            reg_index;
        logic [7:0]            reg_value;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] fetch_address = '0;
    logic [2:0]  instr_kind = '0;
    logic [4:0]  source_a = '0;
    logic [15:0] source_b = '0;
    logic [4:0]  dest_register = '0;
    logic        data_hit = 1'b0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        retired;
    logic [31:0] retired_address;
    logic [8:0]  cycles_added;
    logic        mispredicted;
    logic        load_use_stall;
    logic        data_miss;
    logic [31:0] cycle_total;
    logic [31:0] retired_total;
    logic [31:0] branch_total;
    logic [31:0] correct_total;

    // predictor state: stage entries, counters and its own copy of the registers
    pht_pkg::stage_entry_t stage_regs [4];
    logic [31:0]  cycle_count = '0;
    logic [31:0]  retire_count = '0;
    logic [31:0]  branch_tally = '0;
    logic [31:0]  correct_count = '0;
    logic         model_predict_taken = 1'b0;
    logic [7:0]   model_miss_delay = pht_pkg::MISS_DELAY_RESET;

    pht_pkg::result_t pending_results [$];
    directed_row_t    directed_rows [$];

    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hang_cycles = 0;
    logic [31:0] next_pc = 32'h0000_1000;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    pipeline_hazard_timing_model dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .fetch_address(fetch_address),
        .instr_kind(instr_kind),
        .source_a(source_a),
        .source_b(source_b),
        .dest_register(dest_register),
        .data_hit(data_hit),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .retired(retired),
        .retired_address(retired_address),
        .cycles_added(cycles_added),
        .mispredicted(mispredicted),
        .load_use_stall(load_use_stall),
        .data_miss(data_miss),
        .cycle_total(cycle_total),
        .retired_total(retired_total),
        .branch_total(branch_total),
        .correct_total(correct_total)
    );

    // one step of the timing model: retire, judge the branch, look for hazards
    // and misses, charge the cycles, then shift the stages
    function automatic pht_pkg::result_t advance_pipeline(pht_pkg::stage_entry_t fetched);
        pht_pkg::stage_entry_t f;
        pht_pkg::result_t      r;
        logic [31:0]  seq_addr;
        logic         taken;
        logic [8:0]   charge;
        f = (fetched.addr == '0) ? '0 : fetched;
        r = '0;
        charge = 9'd1;

        if (stage_regs[STG_WB].addr != '0)
        begin
            r.retired = 1'b1;
            r.retired_address = stage_regs[STG_WB].addr;
            retire_count = retire_count + 1;
        end

        // a branch is taken when the next fetch is not the fall-through address;
        // a bubble behind it leaves the guess unjudged but still counts the branch
        if (stage_regs[STG_DECODE].kind == pht_pkg::KIND_BRANCH)
        begin
            seq_addr = stage_regs[STG_DECODE].addr + pht_pkg::SEQ_STEP;
            taken = (f.addr != seq_addr);
            if (f.addr != '0)
            begin
                if (taken == model_predict_taken)
                    correct_count = correct_count + 1;
                else
                begin
                    r.mispredicted = 1'b1;
                    charge = charge + 9'd1;
                end
            end
            branch_tally = branch_tally + 1;
        end

        // load in memory feeding the instruction right behind it
        if (stage_regs[STG_MEM].kind == pht_pkg::KIND_LOAD)
        begin
            if (stage_regs[STG_ALU].kind == pht_pkg::KIND_ALU)
                r.load_use_stall = (stage_regs[STG_ALU].ra == stage_regs[STG_MEM].rd)
                                || (stage_regs[STG_ALU].rb == stage_regs[STG_MEM].rd);
            else if (stage_regs[STG_ALU].kind == pht_pkg::KIND_LOAD
                     || stage_regs[STG_ALU].kind == pht_pkg::KIND_STORE)
                r.load_use_stall = (stage_regs[STG_ALU].ra == stage_regs[STG_MEM].rd);
            if (r.load_use_stall)
                charge = charge + 9'd1;
        end

        // a zero miss penalty still flags the miss but adds nothing
        if ((stage_regs[STG_MEM].kind == pht_pkg::KIND_LOAD
             || stage_regs[STG_MEM].kind == pht_pkg::KIND_STORE)
            && !stage_regs[STG_MEM].hit)
        begin
            r.data_miss = 1'b1;
            if (model_miss_delay != '0)
                charge = charge + (model_miss_delay - 8'd1);
        end

        cycle_count = cycle_count + charge;

        stage_regs[STG_WB] = stage_regs[STG_MEM];
        stage_regs[STG_MEM] = stage_regs[STG_ALU];
        stage_regs[STG_ALU] = stage_regs[STG_DECODE];
        stage_regs[STG_DECODE] = f;

        r.cycles_added = charge;
        r.cycle_total = cycle_count;
        r.retired_total = retire_count;
        r.branch_total = branch_tally;
        r.correct_total = correct_count;
        return r;
    endfunction

    function automatic bit same_result(pht_pkg::result_t a, pht_pkg::result_t b);
        return a.retired === b.retired
            && a.retired_address === b.retired_address
            && a.cycles_added === b.cycles_added
            && a.mispredicted === b.mispredicted
            && a.load_use_stall === b.load_use_stall
            && a.data_miss === b.data_miss
            && a.cycle_total === b.cycle_total
            && a.retired_total === b.retired_total
            && a.branch_total === b.branch_total
            && a.correct_total === b.correct_total;
    endfunction

    function automatic pht_pkg::stage_entry_t instr(logic [31:0] addr, logic [2:0] kind,
                                                    logic [4:0] ra, logic [15:0] rb,
                                                    logic [4:0] rd, logic hit);
        pht_pkg::stage_entry_t e;
        e.addr = addr;
        e.kind = kind;
        e.ra = ra;
        e.rb = rb;
        e.rd = rd;
        e.hit = hit;
        return e;
    endfunction

    function automatic pht_pkg::result_t known_result(logic ret, logic [31:0] ret_addr,
                                                      logic [8:0] cyc, logic mp, logic lu,
                                                      logic dm, logic [31:0] ct,
                                                      logic [31:0] rt, logic [31:0] bt,
                                                      logic [31:0] cr);
        pht_pkg::result_t r;
        r.retired = ret;
        r.retired_address = ret_addr;
        r.cycles_added = cyc;
        r.mispredicted = mp;
        r.load_use_stall = lu;
        r.data_miss = dm;
        r.cycle_total = ct;
        r.retired_total = rt;
        r.branch_total = bt;
        r.correct_total = cr;
        return r;
    endfunction

    function automatic void add_fetch(pht_pkg::stage_entry_t f);
        directed_row_t row;
        row = '{op: ROW_FETCH, fetch: f, has_result: 1'b0, result: '0,
                reg_index: '0, reg_value: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(pht_pkg::stage_entry_t f, pht_pkg::result_t r);
        directed_row_t row;
        row = '{op: ROW_FETCH, fetch: f, has_result: 1'b1, result: r,
                reg_index: '0, reg_value: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_write(logic [1:0] index, logic [7:0] value);
        directed_row_t row;
        row = '{op: ROW_WRITE, fetch: '0, has_result: 1'b0, result: '0,
                reg_index: index, reg_value: value};
        directed_rows.push_back(row);
    endfunction

    // mostly well-formed instruction streams: sequential pcs, branches that
    // fall through or jump, a small register pool so hazards actually occur;
    // the rest is bubbles and fully random noise
    function automatic pht_pkg::stage_entry_t random_fetch();
        pht_pkg::stage_entry_t f;
        int unsigned  roll;
        int unsigned  shape;
        shape = $urandom_range(0, 99);
        roll = $urandom_range(0, 99);
        f.addr = next_pc;
        if (roll < 10)
            f.kind = KIND_OTHER;
        else if (roll < 35)
            f.kind = pht_pkg::KIND_ALU;
        else if (roll < 58)
            f.kind = pht_pkg::KIND_LOAD;
        else if (roll < 72)
            f.kind = pht_pkg::KIND_STORE;
        else if (roll < 92)
            f.kind = pht_pkg::KIND_BRANCH;
        else
            f.kind = $urandom_range(pht_pkg::KIND_BRANCH + 1, KIND_UNDEFINED);
        f.ra = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom;
        f.rd = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom;
        f.rb = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom;
        f.hit = ($urandom_range(0, 99) < 75);

        if (shape < 6)
        begin
            // bubble with whatever junk rides along
            f.addr = '0;
            return f;
        end
        if (shape < 10)
        begin
            f.addr = $urandom;
            f.kind = $urandom_range(0, 7);
            f.ra = $urandom;
            f.rb = $urandom;
            f.rd = $urandom;
        end

        if ((f.kind == pht_pkg::KIND_BRANCH && $urandom_range(0, 1) == 1) || shape > 95)
            next_pc = $urandom;
        else
            next_pc = f.addr + pht_pkg::SEQ_STEP;
        return f;
    endfunction

    // drop valid and wait until every result has come back
    task automatic settle_pipeline();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // registers only change while nothing is in flight
    task automatic write_register(logic [1:0] index, logic [7:0] value);
        settle_pipeline();
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            pht_pkg::CFG_PREDICT_TAKEN: model_predict_taken = value[0];
            pht_pkg::CFG_MISS_DELAY:    model_miss_delay = value;
            default: ;
        endcase
    endtask

    // one fetch transfer: each cycle idles with the set chance, then hold until accepted
    task automatic send_fetch(pht_pkg::stage_entry_t f, bit use_known,
                              pht_pkg::result_t known);
        pht_pkg::result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        fetch_address <= f.addr;
        instr_kind <= f.kind;
        source_a <= f.ra;
        source_b <= f.rb;
        dest_register <= f.rd;
        data_hit <= f.hit;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = advance_pipeline(f);
        pending_results.push_back(use_known ? known : predicted);
    endtask

    task automatic run_phase(int send_pct, int recv_pct, logic [7:0] predict_value,
                             logic [7:0] delay_value, int count);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        write_register(pht_pkg::CFG_PREDICT_TAKEN, predict_value);
        write_register(pht_pkg::CFG_MISS_DELAY, delay_value);
        for (int i = 0; i < count; i++)
        begin
            // hold off once per phase until the block has drained
            if (i == count / 2)
                settle_pipeline();
            send_fetch(random_fetch(), 1'b0, '0);
        end
    endtask

    // result side: random stall, and each result transfer checked against the
    // oldest expectation
    always @(posedge clk)
    begin : result_check
        pht_pkg::result_t seen;
        pht_pkg::result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            seen = {retired, retired_address, cycles_added, mispredicted, load_use_stall,
                    data_miss, cycle_total, retired_total, branch_total, correct_total};
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result transfer at %0t: retired_address %h",
                             $realtime, seen.retired_address);
            end
            else
            begin
                want = pending_results.pop_front();
                if (!same_result(want, seen))
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("result mismatch at %0t (expected / actual)", $realtime);
                        $display("  retired %0b / %0b  address %h / %h  cycles %0d / %0d",
                                 want.retired, seen.retired, want.retired_address,
                                 seen.retired_address, want.cycles_added, seen.cycles_added);
                        $display("  mispredicted %0b / %0b  load_use %0b / %0b  miss %0b / %0b",
                                 want.mispredicted, seen.mispredicted, want.load_use_stall,
                                 seen.load_use_stall, want.data_miss, seen.data_miss);
                        $display("  cycle_total %0d / %0d  retired_total %0d / %0d",
                                 want.cycle_total, seen.cycle_total,
                                 want.retired_total, seen.retired_total);
                        $display("  branch_total %0d / %0d  correct_total %0d / %0d",
                                 want.branch_total, seen.branch_total,
                                 want.correct_total, seen.correct_total);
                    end
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // hang detector: any transfer on either side clears the count
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0)
            || (out_valid === 1'b1 && out_stall === 1'b0))
            hang_cycles <= 0;
        else
            hang_cycles <= hang_cycles + 1;
        if (hang_cycles >= HANG_LIMIT)
        begin
            $display("no transfer for %0d cycles", HANG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        foreach (stage_regs[s])
            stage_regs[s] = '0;

        // rows with typed results start from reset, where every total is easy
        // to follow by hand
        // undefined kind at the top address, all fields at their maximum
        add_checked(instr(32'hFFFF_FFFF, KIND_UNDEFINED, 5'd31, 16'hFFFF, 5'd31, 1'b1),
                    known_result(1'b0, 32'h0, 9'd1, 1'b0, 1'b0, 1'b0, 32'd1, 32'd0, 32'd0, 32'd0));
        // bubble fetch carrying a load miss that must be dropped
        add_checked(instr(32'h0, pht_pkg::KIND_LOAD, 5'd5, 16'h1234, 5'd7, 1'b0),
                    known_result(1'b0, 32'h0, 9'd1, 1'b0, 1'b0, 1'b0, 32'd2, 32'd0, 32'd0, 32'd0));
        add_checked(instr(32'h100, pht_pkg::KIND_BRANCH, 5'd0, 16'h0, 5'd0, 1'b1),
                    known_result(1'b0, 32'h0, 9'd1, 1'b0, 1'b0, 1'b0, 32'd3, 32'd0, 32'd0, 32'd0));
        // fall-through after a branch: predicted not taken, so correct
        add_checked(instr(32'h104, pht_pkg::KIND_BRANCH, 5'd0, 16'h0, 5'd0, 1'b1),
                    known_result(1'b0, 32'h0, 9'd1, 1'b0, 1'b0, 1'b0, 32'd4, 32'd0, 32'd1, 32'd1));
        // jump after a branch: mispredict, and the first fetch retires
        add_checked(instr(32'h200, pht_pkg::KIND_BRANCH, 5'd0, 16'h0, 5'd0, 1'b1),
                    known_result(1'b1, 32'hFFFF_FFFF, 9'd2, 1'b1, 1'b0, 1'b0,
                                 32'd6, 32'd1, 32'd2, 32'd1));
        // branch followed by a bubble: counted but not judged
        add_fetch(instr(32'h0, pht_pkg::KIND_BRANCH, 5'd31, 16'hFFFF, 5'd31, 1'b0));
        // load miss, then an alu op reading it through source a
        add_fetch(instr(32'h300, pht_pkg::KIND_LOAD, 5'd3, 16'h0, 5'd9, 1'b0));
        add_fetch(instr(32'h304, pht_pkg::KIND_ALU, 5'd9, 16'h0, 5'd0, 1'b1));
        // load hit, then an alu op reading it through source b
        add_fetch(instr(32'h308, pht_pkg::KIND_LOAD, 5'd0, 16'h0, 5'd10, 1'b1));
        add_fetch(instr(32'h30C, pht_pkg::KIND_ALU, 5'd0, 16'd10, 5'd0, 1'b1));
        // load then a store using it as base, the store missing
        add_fetch(instr(32'h310, pht_pkg::KIND_LOAD, 5'd0, 16'h0, 5'd11, 1'b1));
        add_fetch(instr(32'h314, pht_pkg::KIND_STORE, 5'd11, 16'h0, 5'd0, 1'b0));
        // load then a load using it as base
        add_fetch(instr(32'h318, pht_pkg::KIND_LOAD, 5'd0, 16'h0, 5'd12, 1'b1));
        add_fetch(instr(32'h31C, pht_pkg::KIND_LOAD, 5'd12, 16'h0, 5'd1, 1'b0));
        // predict taken, largest miss penalty
        add_write(pht_pkg::CFG_PREDICT_TAKEN, 8'd1);
        add_write(pht_pkg::CFG_MISS_DELAY, 8'd255);
        add_fetch(instr(32'h400, pht_pkg::KIND_BRANCH, 5'd0, 16'h0, 5'd0, 1'b1));
        add_fetch(instr(32'h500, KIND_OTHER, 5'd0, 16'h0, 5'd0, 1'b1));
        add_fetch(instr(32'h504, pht_pkg::KIND_BRANCH, 5'd0, 16'h0, 5'd0, 1'b1));
        add_fetch(instr(32'h508, KIND_OTHER, 5'd0, 16'h0, 5'd0, 1'b1));
        // every charge at once: load miss, load-use, mispredicted branch
        add_fetch(instr(32'h700, pht_pkg::KIND_LOAD, 5'd0, 16'h0, 5'd5, 1'b0));
        add_fetch(instr(32'h704, pht_pkg::KIND_ALU, 5'd5, 16'h0, 5'd0, 1'b1));
        add_fetch(instr(32'h708, pht_pkg::KIND_BRANCH, 5'd0, 16'h0, 5'd0, 1'b1));
        add_fetch(instr(32'h70C, KIND_OTHER, 5'd0, 16'h0, 5'd0, 1'b1));
        // zero penalty and writes to indexes that decode to nothing
        add_write(pht_pkg::CFG_MISS_DELAY, 8'd0);
        add_write(CFG_SPARE_LO, 8'h55);
        add_write(CFG_SPARE_HI, 8'hAA);
        add_fetch(instr(32'hA00, pht_pkg::KIND_STORE, 5'd0, 16'h0, 5'd0, 1'b0));
        add_fetch(instr(32'hA04, KIND_OTHER, 5'd0, 16'h0, 5'd0, 1'b1));
        add_fetch(instr(32'hA08, KIND_OTHER, 5'd0, 16'h0, 5'd0, 1'b1));
        add_fetch(instr(32'hA0C, KIND_OTHER, 5'd0, 16'h0, 5'd0, 1'b1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 12;
        recv_stall_pct = 61;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].op == ROW_WRITE)
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
            else
                send_fetch(directed_rows[i].fetch, directed_rows[i].has_result,
                           directed_rows[i].result);
        end

        // random streams: slow receiver, then slow sender, then full rate
        run_phase(12, 61, 8'd0, $urandom_range(2, 254), 434);
        run_phase(61, 12, 8'hFF, 8'd1, 433);
        run_phase(0, 0, $urandom_range(0, 255), 8'd255, 433);

        settle_pipeline();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
